// ===== hw/rtl/tjafk_pkg.sv =====
// ----------------------------------------------------------------------------
// tjafk_pkg
// Shared types and constants for the arm forward kinematics block.
// ----------------------------------------------------------------------------
package tjafk_pkg;

    localparam int LINK_W  = 10;
    localparam int POS_W   = 17;
    localparam int YAW_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int TABLE_LEN = 24;
    // CORDIC datapath width: Q30 with headroom and sign
    localparam int CW      = 34;
    localparam int ZW      = 34;
    localparam int TRIG_W  = 18;   // Q16 trig, signed

    localparam logic [CW-1:0] GAIN_Q30 = CW'(652032874);

    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REACH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP  = 2'd3;

    localparam logic [10:0] RESET_UPPER = 11'd555;
    localparam logic [10:0] RESET_LOWER = 11'd450;
    localparam logic [10:0] RESET_REACH = 11'd43;
    localparam logic [10:0] RESET_DROP  = 11'd20;

    typedef struct packed {
        logic [LINK_W-1:0] upper;
        logic [LINK_W-1:0] lower;
        logic [LINK_W-1:0] reach;
        logic [LINK_W-1:0] drop;
    } link_cfg_t;

    function automatic logic [ZW-1:0] atan_turn32(input int i);
        logic [ZW-1:0] r;
        case (i)
            0:  r = ZW'(536870912);
            1:  r = ZW'(316933406);
            2:  r = ZW'(167458907);
            3:  r = ZW'(85004756);
            4:  r = ZW'(42667331);
            5:  r = ZW'(21354465);
            6:  r = ZW'(10679838);
            7:  r = ZW'(5340245);
            8:  r = ZW'(2670163);
            9:  r = ZW'(1335087);
            10: r = ZW'(667544);
            11: r = ZW'(333772);
            12: r = ZW'(166886);
            13: r = ZW'(83443);
            14: r = ZW'(41722);
            15: r = ZW'(20861);
            16: r = ZW'(10430);
            17: r = ZW'(5215);
            18: r = ZW'(2608);
            19: r = ZW'(1304);
            20: r = ZW'(652);
            21: r = ZW'(326);
            22: r = ZW'(163);
            23: r = ZW'(81);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/tjafk_if.sv =====
// ----------------------------------------------------------------------------
// tjafk_if
// Valid/ready channel interfaces: angle input, position output, config write.
// ----------------------------------------------------------------------------
interface tjafk_angle_if #(
    parameter int ANGLE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] base_angle;
    logic [ANGLE_BITS-1:0] shoulder_angle;
    logic [ANGLE_BITS-1:0] elbow_angle;

    modport source (output valid, base_angle, shoulder_angle, elbow_angle, input ready);
    modport sink   (input valid, base_angle, shoulder_angle, elbow_angle, output ready);
endinterface

interface tjafk_pos_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic        [16:0] hand_yaw;

    modport source (output valid, pos_x, pos_y, pos_z, hand_yaw, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, hand_yaw, output ready);
endinterface

interface tjafk_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tjafk_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// tjafk_cordic_stage
// One registered CORDIC micro-rotation for three angles in parallel.
// ----------------------------------------------------------------------------
module tjafk_cordic_stage
    import tjafk_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in [3],
    input  logic signed [CW-1:0] y_in [3],
    input  logic signed [ZW-1:0] z_in [3],
    output logic signed [CW-1:0] x_reg [3],
    output logic signed [CW-1:0] y_reg [3],
    output logic signed [ZW-1:0] z_reg [3]
);

    localparam logic signed [ZW-1:0] ATAN = atan_turn32(STEP);

    logic signed [CW-1:0] x_next [3];
    logic signed [CW-1:0] y_next [3];
    logic signed [ZW-1:0] z_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!z_in[k][ZW-1])
            begin
                x_next[k] = x_in[k] - (y_in[k] >>> STEP);
                y_next[k] = y_in[k] + (x_in[k] >>> STEP);
                z_next[k] = z_in[k] - ATAN;
            end
            else
            begin
                x_next[k] = x_in[k] + (y_in[k] >>> STEP);
                y_next[k] = y_in[k] - (x_in[k] >>> STEP);
                z_next[k] = z_in[k] + ATAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

// ===== hw/rtl/tjafk_kin.sv =====
// ----------------------------------------------------------------------------
// tjafk_kin
// Kinematics back end: link products, base rotation, rounding, saturation.
// Four register stages, stalled as one with the pipeline enable.
// ----------------------------------------------------------------------------
module tjafk_kin
    import tjafk_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  link_cfg_t                cfg,
    input  logic signed [TRIG_W-1:0] c_in [3],
    input  logic signed [TRIG_W-1:0] s_in [3],
    output logic signed [POS_W-1:0]  pos_x,
    output logic signed [POS_W-1:0]  pos_y,
    output logic signed [POS_W-1:0]  pos_z
);

    // stage 1: link products
    logic signed [28:0] p_s1_reg, p_s2_reg, p_c1_reg, p_c2_reg;
    logic signed [TRIG_W-1:0] c0_1_reg, s0_1_reg;
    // stage 2: reach and height
    logic signed [30:0] reach_reg, height_reg;
    logic signed [TRIG_W-1:0] c0_2_reg, s0_2_reg;
    // stage 3: rotation products
    logic signed [49:0] px_reg, py_reg;
    logic signed [30:0] height3_reg;

    logic signed [10:0] l0, l1;
    logic signed [49:0] px_r, py_r;
    logic signed [30:0] hz_r;
    logic signed [POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;

    assign l0 = signed'({1'b0, cfg.upper});
    assign l1 = signed'({1'b0, cfg.lower});

    function automatic logic signed [POS_W-1:0] sat(input logic signed [49:0] v);
        if (v > 50'sd65535)
            return POS_W'(65535);
        else if (v < -50'sd65536)
            return POS_W'(-65536);
        else
            return v[POS_W-1:0];
    endfunction

    always_comb
    begin
        px_r = (-px_reg + 50'sd134217728) >>> 28;
        py_r = (py_reg + 50'sd134217728) >>> 28;
        hz_r = (height3_reg + 31'sd2048) >>> 12;
        pos_x_next = sat(px_r);
        pos_y_next = sat(py_r);
        pos_z_next = sat(50'(hz_r));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_s1_reg <= 29'(l0 * s_in[1]);
            p_s2_reg <= 29'(l1 * s_in[2]);
            p_c1_reg <= 29'(l0 * c_in[1]);
            p_c2_reg <= 29'(l1 * c_in[2]);
            c0_1_reg <= c_in[0];
            s0_1_reg <= s_in[0];

            reach_reg  <= 31'(p_s1_reg) + 31'(p_s2_reg)
                        + signed'({5'd0, cfg.reach, 16'd0});
            height_reg <= 31'(p_c1_reg) + 31'(p_c2_reg)
                        - signed'({5'd0, cfg.drop, 16'd0});
            c0_2_reg <= c0_1_reg;
            s0_2_reg <= s0_1_reg;

            px_reg <= 50'(reach_reg * s0_2_reg);
            py_reg <= 50'(reach_reg * c0_2_reg);
            height3_reg <= height_reg;

            pos_x <= pos_x_next;
            pos_y <= pos_y_next;
            pos_z <= pos_z_next;
        end
    end

endmodule

// ===== hw/rtl/three_joint_arm_forward_kinematics.sv =====
// ----------------------------------------------------------------------------
// three_joint_arm_forward_kinematics
// Pipelined forward kinematics of a base-rotating two-link arm.
// ----------------------------------------------------------------------------
// Usage:
//   angles  : sink channel, one transfer carries base, shoulder and elbow
//             angles (2^ANGLE_BITS units per turn).
//   result  : source channel, one transfer per accepted angle set, carrying
//             pos_x/pos_y/pos_z in 1/16 mm (saturated) and hand_yaw.
//   cfg     : register writes; index 0..3 selects upper link, lower link,
//             reach offset and drop offset. Write only while idle.
// Throughput: one angle set per cycle while the output is not stalled.
// Pipeline: a seed stage, one register per CORDIC micro-rotation (iterations
//   capped at 24), then the quadrant, product, sum, rotation and rounding
//   stages lie between an input transfer and its output transfer.
// Reset: empties the pipeline and loads the link registers with their
//   default lengths (555, 450, 43, 20 mm).
// Stall: the whole pipeline holds while the output is valid and not taken;
//   in_ready follows out ready then, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module three_joint_arm_forward_kinematics
    import tjafk_pkg::*;
#(
    parameter int ANGLE_BITS        = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic clk,
    input  logic rst_n,
    tjafk_angle_if.sink  angles,
    tjafk_pos_if.source  result,
    tjafk_cfg_if.sink    cfg
);

    localparam int NIT    = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
    // 1 input stage, NIT cordic, 1 quadrant/round, 4 kinematics
    localparam int DEPTH  = NIT + 6;

    link_cfg_t cfg_reg;
    logic [DEPTH-1:0] vld_reg;
    logic en;

    // advance whenever the output slot is empty or being taken
    assign en = !vld_reg[DEPTH-1] || result.ready;
    assign angles.ready = en;
    assign cfg.ready = 1'b1;

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper <= RESET_UPPER[LINK_W-1:0];
            cfg_reg.lower <= RESET_LOWER[LINK_W-1:0];
            cfg_reg.reach <= RESET_REACH[LINK_W-1:0];
            cfg_reg.drop  <= RESET_DROP[LINK_W-1:0];
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_UPPER: cfg_reg.upper <= cfg.data;
                REG_LOWER: cfg_reg.lower <= cfg.data;
                REG_REACH: cfg_reg.reach <= cfg.data;
                REG_DROP:  cfg_reg.drop  <= cfg.data;
                default:   ;
            endcase
        end
    end

    // ---- valid chain ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], angles.valid};
    end

    // ---- stage 0: split quadrant, build CORDIC seeds; hold yaw ----
    logic signed [CW-1:0] x_seed_reg [3];
    logic signed [CW-1:0] y_seed_reg [3];
    logic signed [ZW-1:0] z_seed_reg [3];
    logic [1:0]           quad_pipe_reg [NIT+1][3];
    logic [YAW_W-1:0]     yaw_pipe_reg [DEPTH];
    logic [ANGLE_BITS-1:0] ang [3];
    logic [YAW_W-1:0]     yaw_next;

    assign ang[0] = angles.base_angle;
    assign ang[1] = angles.shoulder_angle;
    assign ang[2] = angles.elbow_angle;
    assign yaw_next = YAW_W'({1'b0, angles.base_angle} + {1'b0, angles.shoulder_angle});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x_seed_reg[k] <= GAIN_Q30;
                y_seed_reg[k] <= '0;
                // quarter turn maps to 2^30
                z_seed_reg[k] <= ZW'({ang[k][ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
                quad_pipe_reg[0][k] <= ang[k][ANGLE_BITS-1 -: 2];
            end
            for (int j = 1; j <= NIT; j++)
                quad_pipe_reg[j] <= quad_pipe_reg[j-1];
            yaw_pipe_reg[0] <= yaw_next;
            for (int j = 1; j < DEPTH; j++)
                yaw_pipe_reg[j] <= yaw_pipe_reg[j-1];
        end
    end

    // ---- CORDIC stages ----
    logic signed [CW-1:0] xs [NIT+1][3];
    logic signed [CW-1:0] ys [NIT+1][3];
    logic signed [ZW-1:0] zs [NIT+1][3];

    assign xs[0] = x_seed_reg;
    assign ys[0] = y_seed_reg;
    assign zs[0] = z_seed_reg;

    for (genvar g = 0; g < NIT; g++)
    begin : g_cordic
        tjafk_cordic_stage #(.STEP(g)) u_stage (
            .clk   (clk),
            .en    (en),
            .x_in  (xs[g]),
            .y_in  (ys[g]),
            .z_in  (zs[g]),
            .x_reg (xs[g+1]),
            .y_reg (ys[g+1]),
            .z_reg (zs[g+1])
        );
    end

    // ---- round to Q16 and fold the quadrant back ----
    logic signed [TRIG_W-1:0] c_reg [3];
    logic signed [TRIG_W-1:0] s_reg [3];
    logic signed [CW-1:0] cr [3];
    logic signed [CW-1:0] sr [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cr[k] = (xs[NIT][k] + CW'(8192)) >>> 14;
            sr[k] = (ys[NIT][k] + CW'(8192)) >>> 14;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (quad_pipe_reg[NIT][k])
                    2'd0:
                    begin
                        c_reg[k] <= cr[k][TRIG_W-1:0];
                        s_reg[k] <= sr[k][TRIG_W-1:0];
                    end
                    2'd1:
                    begin
                        c_reg[k] <= -sr[k][TRIG_W-1:0];
                        s_reg[k] <= cr[k][TRIG_W-1:0];
                    end
                    2'd2:
                    begin
                        c_reg[k] <= -cr[k][TRIG_W-1:0];
                        s_reg[k] <= -sr[k][TRIG_W-1:0];
                    end
                    default:
                    begin
                        c_reg[k] <= sr[k][TRIG_W-1:0];
                        s_reg[k] <= -cr[k][TRIG_W-1:0];
                    end
                endcase
            end
        end
    end

    // ---- kinematics back end ----
    tjafk_kin u_kin (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .c_in  (c_reg),
        .s_in  (s_reg),
        .pos_x (result.pos_x),
        .pos_y (result.pos_y),
        .pos_z (result.pos_z)
    );

    assign result.valid    = vld_reg[DEPTH-1];
    assign result.hand_yaw = yaw_pipe_reg[DEPTH-1];

endmodule

// ===== hw/rtl/tjafk_checker.sv =====
// ----------------------------------------------------------------------------
// tjafk_checker
// Port-level checks for the forward kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
module tjafk_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] yaw
);

    // a waiting result blocks input only when it is not being taken
    a_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> in_ready)
        else $error("input stalled while output drains");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(yaw)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind three_joint_arm_forward_kinematics tjafk_port_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (angles.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .yaw       (result.hand_yaw)
);

// ===== bench/tjafk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tjafk_checker
// Watches the angle, position and register channels, predicts each hand
// position from the accepted angles and compares it with the block's output.
// ----------------------------------------------------------------------------
module tjafk_checker
    import tjafk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tjafk_angle_if angles,
    tjafk_pos_if   result,
    tjafk_cfg_if   cfg,
    output int     fail_count,
    output int     pending,
    output int     matched
);

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic [16:0]        yaw;
    } hand_pos_t;

    localparam int ITERS = 16;

    hand_pos_t     pos_queue[$];
    logic [9:0]    link_mm[4];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Q16 cosine and sine from a rotation-mode CORDIC over one quadrant
    task automatic angle_trig(input logic [15:0] a, output longint c_q, output longint s_q);
        longint cx;
        longint cy;
        longint cz;
        longint nx;
        longint c;
        longint s;
        logic [1:0] quad;
        cx   = 652032874;
        cy   = 0;
        quad = a[15:14];
        cz   = longint'({a[13:0], 16'd0});
        for (int i = 0; i < ITERS; i++)
        begin
            if (cz >= 0)
            begin
                nx = cx - floor_shift(cy, i);
                cy = cy + floor_shift(cx, i);
                cz = cz - longint'(atan_turn32(i));
            end
            else
            begin
                nx = cx + floor_shift(cy, i);
                cy = cy - floor_shift(cx, i);
                cz = cz + longint'(atan_turn32(i));
            end
            cx = nx;
        end
        c = floor_shift(cx + (64'sd1 <<< 13), 14);
        s = floor_shift(cy + (64'sd1 <<< 13), 14);
        case (quad)
            2'd0:    begin c_q = c;  s_q = s;  end
            2'd1:    begin c_q = -s; s_q = c;  end
            2'd2:    begin c_q = -c; s_q = -s; end
            default: begin c_q = s;  s_q = -c; end
        endcase
    endtask

    function automatic logic signed [16:0] clamp_pos(longint v);
        if (v > 65535)
            return 17'sd65535;
        if (v < -65536)
            return -17'sd65536;
        return v[16:0];
    endfunction

    task automatic predict_hand(input logic [15:0] a0, input logic [15:0] a1,
                                input logic [15:0] a2, output hand_pos_t p);
        longint c0, s0, c1, s1, c2, s2, reach, height;
        angle_trig(a0, c0, s0);
        angle_trig(a1, c1, s1);
        angle_trig(a2, c2, s2);
        reach  = link_mm[REG_UPPER] * s1 + link_mm[REG_LOWER] * s2
               + link_mm[REG_REACH] * 65536;
        height = link_mm[REG_UPPER] * c1 + link_mm[REG_LOWER] * c2
               - link_mm[REG_DROP] * 65536;
        p.x   = clamp_pos(floor_shift(-(reach * s0) + (64'sd1 <<< 27), 28));
        p.y   = clamp_pos(floor_shift(reach * c0 + (64'sd1 <<< 27), 28));
        p.z   = clamp_pos(floor_shift(height + (64'sd1 <<< 11), 12));
        p.yaw = {1'b0, a0} + {1'b0, a1};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hand_pos_t want;
        hand_pos_t seen;
        if (!rst_n)
        begin
            link_mm[REG_UPPER] = 10'd555;
            link_mm[REG_LOWER] = 10'd450;
            link_mm[REG_REACH] = 10'd43;
            link_mm[REG_DROP]  = 10'd20;
            pos_queue.delete();
            fail_count = 0;
            pending    = 0;
            matched    = 0;
        end
        else
        begin
            // Compare the output first: it was predicted before this edge
            if (result.valid && result.ready)
            begin
                seen = '{result.pos_x, result.pos_y, result.pos_z, result.hand_yaw};
                if (pos_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected position transfer %p", $time, seen);
                end
                else
                begin
                    want = pos_queue.pop_front();
                    if (want !== seen)
                    begin
                        fail_count++;
                        $display("%0t: expected x=%0d y=%0d z=%0d yaw=%0d, got x=%0d y=%0d z=%0d yaw=%0d",
                                 $time, want.x, want.y, want.z, want.yaw,
                                 seen.x, seen.y, seen.z, seen.yaw);
                    end
                    else
                        matched++;
                end
            end
            if (angles.valid && angles.ready)
            begin
                predict_hand(angles.base_angle, angles.shoulder_angle,
                             angles.elbow_angle, want);
                pos_queue.push_back(want);
            end
            if (cfg.valid && cfg.ready)
                link_mm[cfg.index] = cfg.data;
            pending = pos_queue.size();
        end
    end

endmodule

// ===== bench/three_joint_arm_forward_kinematics_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_joint_arm_forward_kinematics_tb
// Drives angle sets and link register writes into the arm kinematics block
// under varied flow control; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module three_joint_arm_forward_kinematics_tb;
    import tjafk_pkg::*;

    localparam int LATENCY    = 16 + 7;
    localparam int STALL_MAX  = 5000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   matched;
    int   send_idle_pct;
    int   take_idle_pct;
    bit   hold_output;
    int   idle_cycles;
    int   sent_items;
    int   cfg_writes;

    tjafk_angle_if angles ();
    tjafk_pos_if   result ();
    tjafk_cfg_if   cfg ();

    three_joint_arm_forward_kinematics u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles),
        .result (result),
        .cfg    (cfg)
    );

    tjafk_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .angles     (angles),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending),
        .matched    (matched)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_output)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Watchdog: count cycles in which nothing is transferred
    always @(posedge clk)
    begin
        if (!rst_n || (angles.valid && angles.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one angle set; idle beforehand at the sender's rate
    task automatic send_angles(input logic [15:0] a0, input logic [15:0] a1,
                               input logic [15:0] a2);
        while ($urandom_range(99) < send_idle_pct)
        begin
            angles.valid <= 1'b0;
            @(posedge clk);
        end
        angles.valid          <= 1'b1;
        angles.base_angle     <= a0;
        angles.shoulder_angle <= a1;
        angles.elbow_angle    <= a2;
        @(posedge clk);
        while (!angles.ready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic drain_pipeline();
        angles.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    task automatic write_link(input logic [1:0] idx, input logic [9:0] len);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= len;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic write_links(input logic [9:0] l0, input logic [9:0] l1,
                               input logic [9:0] l2, input logic [9:0] l3);
        write_link(REG_UPPER, l0);
        write_link(REG_LOWER, l1);
        write_link(REG_REACH, l2);
        write_link(REG_DROP, l3);
        @(posedge clk);
    endtask

    // Mostly plain random angles, some near quadrant edges
    task automatic send_random(input int count);
        logic [15:0] a[3];
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(3) == 0)
                    a[k] = 16'({2'($urandom_range(3)), 14'd0})
                         + 16'($urandom_range(6)) - 16'd3;
                else
                    a[k] = 16'($urandom());
            end
            send_angles(a[0], a[1], a[2]);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        hold_output    = 1'b0;
        sent_items     = 0;
        cfg_writes     = 0;
        send_idle_pct  = 7;
        take_idle_pct  = 56;
        angles.valid   = 1'b0;
        angles.base_angle     = '0;
        angles.shoulder_angle = '0;
        angles.elbow_angle    = '0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_UPPER;
        cfg.data       = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset lengths, extremes and quadrant edges of every angle
        send_angles(16'h0000, 16'h0000, 16'h0000);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h4000, 16'h4000, 16'h4000);
        send_angles(16'h8000, 16'h8000, 16'h8000);
        send_angles(16'hC000, 16'hC000, 16'hC000);
        send_angles(16'h3FFF, 16'h7FFF, 16'hBFFF);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
        send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
        send_angles(16'h2000, 16'hE000, 16'h6000);
        drain_pipeline();

        // Longest links: largest reach and height in every direction, short of saturation
        write_links(10'h3FF, 10'h3FF, 10'h3FF, 10'h000);
        send_angles(16'h0000, 16'h4000, 16'h4000);
        send_angles(16'h4000, 16'h4000, 16'h4000);
        send_angles(16'h8000, 16'h4000, 16'h4000);
        send_angles(16'hC000, 16'h4000, 16'h4000);
        send_angles(16'h0000, 16'h0000, 16'h0000);
        send_angles(16'h0000, 16'h8000, 16'h8000);
        drain_pipeline();

        // Zero links with largest drop: deepest height, reach zero
        write_links(10'h000, 10'h000, 10'h000, 10'h3FF);
        send_angles(16'h1234, 16'hFEDC, 16'h8001);
        send_angles(16'hFFFF, 16'h0001, 16'h7FFF);
        drain_pipeline();

        // Random phase one: sender rarely idles, receiver often stalls
        write_links(10'd555, 10'd450, 10'd43, 10'd20);
        send_random(150);
        drain_pipeline();

        // Long hold-off: keep offering until the block stalls its input
        write_links(10'($urandom()), 10'($urandom()), 10'($urandom()), 10'($urandom()));
        send_idle_pct = 56;
        take_idle_pct = 7;
        hold_output   = 1'b1;
        fork
            begin
                repeat (3 * LATENCY)
                    @(posedge clk);
                hold_output = 1'b0;
            end
            send_random(150);
        join
        drain_pipeline();

        // Random phase three: no idling on either side
        write_links(10'($urandom()), 10'($urandom()), 10'($urandom()), 10'($urandom()));
        send_idle_pct = 0;
        take_idle_pct = 0;
        send_random(150);
        drain_pipeline();

        $display("Covered %0d angle sets, %0d link writes, %0d results checked.",
                 sent_items, cfg_writes, matched);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
